/* hw/rtl/ttsel_pkg.sv */
// ----------------------------------------------------------------------------
// ttsel_pkg
// Shared types and constants of the threshold truncation selector.
// ----------------------------------------------------------------------------
package ttsel_pkg;

	localparam int FitW   = 32;
	localparam int IndexW = 5;
	localparam int RankW  = 5;
	localparam int CountW = 6;

	localparam logic signed [FitW-1:0] ThresholdReset = 32'sd6553600;

	// Configuration register byte addresses.
	localparam logic RegThreshold = 1'b0;

	typedef struct packed {
		logic signed [FitW-1:0] fitness;
		logic                   final_entry;
	} item_t;

	typedef struct packed {
		logic [IndexW-1:0]      individual_index;
		logic signed [FitW-1:0] selected_fitness;
		logic [RankW-1:0]       rank;
		logic [CountW-1:0]      selected_count;
		logic                   none_selected;
		logic                   last_result;
	} result_t;

	// One slot of the sorted chain.
	typedef struct packed {
		logic                   valid;
		logic [IndexW-1:0]      index;
		logic signed [FitW-1:0] fitness;
	} entry_t;

	// Chain-wide commands, one per cycle at most.
	typedef struct packed {
		logic insert;
		logic shift;
		logic clear;
	} ctl_t;

endpackage

/* hw/rtl/ttsel_cell.sv */
// ----------------------------------------------------------------------------
// ttsel_cell
// One slot of the insertion-sort chain: keeps its entry, takes the new entry,
// or takes its upper neighbor's entry on an insert; takes its lower neighbor's
// entry on a shift toward the head; a clear empties it.
// ----------------------------------------------------------------------------
module ttsel_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ttsel_pkg::ctl_t                  ctl,
	input  ttsel_pkg::entry_t                new_entry,
	input  ttsel_pkg::entry_t                prev_entry,
	input  logic                             prev_keep,
	input  ttsel_pkg::entry_t                next_entry,
	input  logic signed [ttsel_pkg::FitW-1:0] threshold,
	output ttsel_pkg::entry_t                entry,
	output logic                             keep,
	output logic                             qual
);
	import ttsel_pkg::*;

	logic                   valid_q;
	logic [IndexW-1:0]      index_q;
	logic signed [FitW-1:0] fitness_q;
	entry_t                 insert_d;

	assign entry = '{valid: valid_q, index: index_q, fitness: fitness_q};

	// Ties stay put, so an earlier arrival ranks ahead of a later equal one.
	assign keep = valid_q && (fitness_q >= new_entry.fitness);
	assign qual = valid_q && (fitness_q > threshold);

	always_comb begin
		if (keep) begin
			insert_d = entry;
		end else if (prev_keep) begin
			insert_d = new_entry;
		end else begin
			insert_d = prev_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.insert) begin
			valid_q <= insert_d.valid;
		end else if (ctl.shift) begin
			valid_q <= next_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			index_q   <= insert_d.index;
			fitness_q <= insert_d.fitness;
		end else if (ctl.shift) begin
			index_q   <= next_entry.index;
			fitness_q <= next_entry.fitness;
		end
	end

endmodule

/* hw/rtl/threshold_truncation_selector.sv */
// ----------------------------------------------------------------------------
// threshold_truncation_selector
// Sorts a population's fitness values as they arrive and reports, best first,
// every individual above the fitness threshold.
// ----------------------------------------------------------------------------
// Each fitness value is inserted into a chain of POPULATION_MAX sorted cells,
// so items may be issued back to back. On the item flagged final_entry the
// block goes busy: in the QUALIFY state it compares every cell with the
// threshold, in COUNT it turns the result into a count, then in EMIT the
// chain shifts one result per cycle out of its head cell. Results appear on
// result for exactly one cycle each with result_valid high and are not held:
// the receiver must take every one. Values beyond a full chain are dropped,
// but a final_entry on such an item still triggers the report.
// ----------------------------------------------------------------------------
module threshold_truncation_selector #(
	parameter int POPULATION_MAX = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  ttsel_pkg::item_t    item,
	output logic                result_valid,
	output ttsel_pkg::result_t  result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import ttsel_pkg::*;

	localparam int N  = POPULATION_MAX;
	localparam int CW = $clog2(N + 1);
	localparam int RW = $clog2(N);

	typedef enum logic [1:0] {IDLE, QUALIFY, COUNT, EMIT} state_t;

	state_t                 state_q;
	logic signed [FitW-1:0] threshold_q;
	logic [CW-1:0]          loaded_q;
	logic [CW-1:0]          count_q;
	logic [RW-1:0]          rank_q;
	logic [N-1:0]           qual_q;

	ctl_t                   ctl;
	entry_t                 new_entry;
	entry_t                 cell_entry [N];
	logic [N-1:0]           cell_keep;
	logic [N-1:0]           cell_qual;
	logic [CW-1:0]          count_d;
	logic                   accept;
	logic                   full;
	logic                   last;
	logic [CW+IndexW-1:0]   loaded_ext;
	logic [CW+CountW-1:0]   count_ext;
	logic [RW+RankW-1:0]    rank_ext;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr == RegThreshold) ? threshold_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= ThresholdReset;
		end else if (psel && penable && pwrite && pready && paddr == RegThreshold) begin
			threshold_q <= pwdata;
		end
	end

	assign busy   = (state_q != IDLE);
	assign accept = start && !busy;
	assign full   = (loaded_q == CW'(N));
	assign last   = (count_q == '0) || ((CW'(rank_q) + CW'(1)) == count_q);

	assign loaded_ext = {{IndexW{1'b0}}, loaded_q};
	assign new_entry  = '{valid: 1'b1, index: loaded_ext[IndexW-1:0], fitness: item.fitness};

	assign ctl.insert = accept && !full;
	assign ctl.shift  = (state_q == EMIT) && !last;
	assign ctl.clear  = (state_q == EMIT) && last;

	// The cell chain.
	for (genvar i = 0; i < N; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_k;

		if (i == 0) begin : g_head
			assign prev_e = '0;
			assign prev_k = 1'b1;
		end else begin : g_body
			assign prev_e = cell_entry[i-1];
			assign prev_k = cell_keep[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign next_e = '0;
		end else begin : g_inner
			assign next_e = cell_entry[i+1];
		end

		ttsel_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.prev_keep  (prev_k),
			.next_entry (next_e),
			.threshold  (threshold_q),
			.entry      (cell_entry[i]),
			.keep       (cell_keep[i]),
			.qual       (cell_qual[i])
		);
	end

	// The qualify flags form a run of ones from the head; the count is where
	// the run ends.
	always_comb begin
		count_d = '0;
		for (int k = 0; k <= N; k++) begin
			if (((k == 0) || qual_q[(k == 0) ? 0 : k-1]) && ((k == N) || !qual_q[(k == N) ? 0 : k])) begin
				count_d = count_d | CW'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			loaded_q <= '0;
			count_q  <= '0;
			rank_q   <= '0;
			qual_q   <= '0;
		end else begin
			if (ctl.insert) begin
				loaded_q <= loaded_q + CW'(1);
			end
			unique case (state_q)
				IDLE: begin
					if (accept && item.final_entry) begin
						state_q <= QUALIFY;
					end
				end
				QUALIFY: begin
					qual_q  <= cell_qual;
					state_q <= COUNT;
				end
				COUNT: begin
					count_q <= count_d;
					rank_q  <= '0;
					state_q <= EMIT;
				end
				EMIT: begin
					if (last) begin
						loaded_q <= '0;
						state_q  <= IDLE;
					end else begin
						rank_q <= rank_q + RW'(1);
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign count_ext = {{CountW{1'b0}}, count_q};
	assign rank_ext  = {{RankW{1'b0}}, rank_q};

	always_comb begin
		result_valid = (state_q == EMIT);
		result       = '0;
		if (count_q == '0) begin
			result.none_selected = 1'b1;
			result.last_result   = 1'b1;
		end else begin
			result.individual_index = cell_entry[0].index;
			result.selected_fitness = cell_entry[0].fitness;
			result.rank             = rank_ext[RankW-1:0];
			result.selected_count   = count_ext[CountW-1:0];
			result.last_result      = last;
		end
	end

endmodule

/* tb/sv/tb_threshold_truncation_selector.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_threshold_truncation_selector
// Self-checking testbench of the threshold truncation selector.
// ----------------------------------------------------------------------------
// Populations of fitness values are sent through the start/busy port. The
// testbench keeps its own ranked list and threshold and predicts the selected
// individuals, best first. Every strobed result is compared field by field
// with the oldest prediction. The threshold is written and read back over
// APB between populations. A directed part and an overflow part come first,
// then random populations with random sender bursts and gaps.
// ----------------------------------------------------------------------------
module tb_threshold_truncation_selector;
	import ttsel_pkg::*;

	localparam int PopMax      = 32;
	localparam int LimitCycles = 200000;

	localparam logic signed [FitW-1:0] FitMax = 32'sh7FFFFFFF;
	localparam logic signed [FitW-1:0] FitMin = 32'sh80000000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        result_valid;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic        paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Ranked copy of the current population, highest fitness first.
	logic signed [FitW-1:0] ranked_fitness [PopMax];
	logic [IndexW-1:0]      ranked_index [PopMax];
	int                     held_count;
	logic signed [FitW-1:0] threshold_shadow;
	logic signed [FitW-1:0] last_fitness;
	result_t                pending_selections [$];

	int errors = 0;
	int cycles = 0;
	int burst_left;

	threshold_truncation_selector #(
		.POPULATION_MAX(PopMax)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.result_valid(result_valid),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LimitCycles) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid) begin
			if (pending_selections.size() == 0) begin
				errors++;
				$display("%0t: result %h with no transaction expected, actual %h", $time,
					result_t'('0), result);
			end else begin
				want = pending_selections.pop_front();
				check_field("individual_index", want.individual_index,
					result.individual_index);
				check_field("selected_fitness", want.selected_fitness,
					result.selected_fitness);
				check_field("rank", want.rank, result.rank);
				check_field("selected_count", want.selected_count, result.selected_count);
				check_field("none_selected", want.none_selected, result.none_selected);
				check_field("last_result", want.last_result, result.last_result);
			end
		end
	end

	// Inserts one fitness into the ranked list unless it is full; on the last
	// individual it queues every individual strictly above the threshold and empties the list.
	function automatic void predict_selection(input logic signed [FitW-1:0] fit,
			input logic fin);
		int      pos;
		int      count;
		result_t r;
		if (held_count < PopMax) begin
			pos = 0;
			// Equal fitness goes behind the earlier arrival.
			while (pos < held_count && ranked_fitness[pos] >= fit)
				pos++;
			for (int k = held_count; k > pos; k--) begin
				ranked_fitness[k] = ranked_fitness[k-1];
				ranked_index[k]   = ranked_index[k-1];
			end
			ranked_fitness[pos] = fit;
			ranked_index[pos]   = IndexW'(held_count);
			held_count++;
		end
		if (!fin)
			return;
		count = 0;
		while (count < held_count && ranked_fitness[count] > threshold_shadow)
			count++;
		if (count == 0) begin
			r = '0;
			r.none_selected = 1'b1;
			r.last_result   = 1'b1;
			pending_selections.push_back(r);
		end
		for (int i = 0; i < count; i++) begin
			r.individual_index = ranked_index[i];
			r.selected_fitness = ranked_fitness[i];
			r.rank             = RankW'(i);
			r.selected_count   = CountW'(count);
			r.none_selected    = 1'b0;
			r.last_result      = (i == count - 1);
			pending_selections.push_back(r);
		end
		held_count = 0;
	endfunction

	task automatic send_item(input logic signed [FitW-1:0] fit, input logic fin);
		@(negedge clk);
		start <= 1'b1;
		item  <= '{fitness: fit, final_entry: fin};
		do
			@(posedge clk);
		while (busy);
		predict_selection(fit, fin);
	endtask

	task automatic rest(input int gap);
		@(negedge clk);
		start <= 1'b0;
		repeat (gap - 1) @(negedge clk);
	endtask

	// Sender bursts of random length separated by random gaps.
	task automatic pace();
		if (burst_left == 0) begin
			rest($urandom_range(1, 6));
			burst_left = $urandom_range(1, 12);
		end else begin
			burst_left--;
		end
	endtask

	// Holds off the sender until every predicted result has been seen and the
	// block has gone idle.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_selections.size() != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic check_threshold_reg();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= RegThreshold;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== threshold_shadow) begin
			errors++;
			$display("%0t: fitness_threshold expected %0h, actual %0h", $time,
				threshold_shadow, prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// The write is followed directly by a read-back transaction.
	task automatic write_threshold(input logic signed [FitW-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= RegThreshold;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		threshold_shadow = value;
		check_threshold_reg();
	endtask

	function automatic logic signed [FitW-1:0] random_fitness();
		logic signed [FitW-1:0] f;
		case ($urandom_range(0, 5))
			0: f = $urandom;
			1: f = threshold_shadow + $signed($urandom_range(0, 6)) - 32'sd3;
			2: f = last_fitness;
			3: f = $urandom_range(0, 1) ? FitMax : FitMin;
			default: f = threshold_shadow + $signed($urandom_range(0, 2097152))
				- 32'sd1048576;
		endcase
		last_fitness = f;
		return f;
	endfunction

	function automatic logic signed [FitW-1:0] random_threshold();
		case ($urandom_range(0, 5))
			0: return ThresholdReset;
			1: return FitMin;
			2: return FitMax;
			3: return -32'sd1;
			4: return $signed($urandom_range(0, 4194304)) - 32'sd2097152;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed_cases();
		// Ties, a value equal to the threshold, one just above, and both extremes.
		send_item(32'sd13107200, 1'b0);
		send_item(32'sd3276800, 1'b0);
		send_item(32'sd13107200, 1'b0);
		send_item(ThresholdReset, 1'b0);
		send_item(ThresholdReset + 32'sd1, 1'b0);
		send_item(FitMax, 1'b0);
		send_item(FitMin, 1'b1);
		// Single individuals: one below the threshold, one at the top.
		send_item(32'sd3276800, 1'b1);
		send_item(FitMax, 1'b1);
		// Nothing can be strictly above the largest threshold.
		drain();
		write_threshold(FitMax);
		send_item(FitMax, 1'b0);
		send_item(FitMax, 1'b1);
		drain();
		write_threshold(FitMin);
		send_item(FitMin, 1'b0);
		send_item(32'sd0, 1'b0);
		send_item(-32'sd1, 1'b1);
		drain();
		write_threshold(-32'sd1);
		send_item(32'sd0, 1'b0);
		send_item(-32'sd1, 1'b0);
		send_item(32'sd0, 1'b1);
	endtask

	// Populations larger than the list: the extra values are dropped, but a
	// final flag on a dropped value still triggers the report.
	task automatic test_full_population();
		drain();
		write_threshold(FitMin);
		for (int i = 0; i < PopMax + 1; i++) begin
			send_item($urandom, i == PopMax);
			pace();
		end
		drain();
		write_threshold(ThresholdReset);
		for (int i = 0; i < PopMax + 4; i++) begin
			send_item(random_fitness(), i == PopMax + 3);
			pace();
		end
	endtask

	task automatic test_random_populations();
		int sent;
		int pops;
		int size;
		sent = 0;
		pops = 0;
		while (sent < 30) begin
			if (pops == 3 || $urandom_range(0, 3) == 0) begin
				drain();
				write_threshold(random_threshold());
			end
			size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, PopMax)
				: $urandom_range(1, 8);
			for (int i = 0; i < size; i++) begin
				send_item(random_fitness(), i == size - 1);
				pace();
			end
			sent += size;
			pops++;
		end
	endtask

	initial begin
		start            = 1'b0;
		item             = '0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = RegThreshold;
		pwdata           = '0;
		arst_n           = 1'b0;
		held_count       = 0;
		threshold_shadow = ThresholdReset;
		last_fitness     = ThresholdReset;
		burst_left       = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		check_threshold_reg();
		test_directed_cases();
		test_full_population();
		test_random_populations();
		drain();
		// A stray result after the last expected one is still caught here.
		repeat (40) @(negedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
